>>> rtl/core/lstk_pkg.sv
package lstk_pkg;

  localparam int DEPTH      = 128;
  localparam int DATA_WIDTH = 32;
  localparam int FIELD_W    = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 8;
  localparam int IDX_W      = 7;
  localparam int LIM_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_SEARCH = 3'd3,
    REQ_UPDATE = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Sign-extend a port field and keep the stored width.
  function automatic logic [DATA_WIDTH-1:0] to_word(input logic [FIELD_W-1:0] f);
    logic signed [63:0] ext;
    ext = 64'($signed(f));
    return ext[DATA_WIDTH-1:0];
  endfunction

  // Sign-extend a stored word back out to the port field width.
  function automatic logic [FIELD_W-1:0] from_word(input logic [DATA_WIDTH-1:0] w);
    logic signed [63:0] ext;
    ext = 64'($signed(w));
    return ext[FIELD_W-1:0];
  endfunction

endpackage

>>> rtl/core/stack_with_search_update_top.sv
// Bounded LIFO stack with search and update, held in a single-port-write,
// registered-read RAM. A request is taken when start_i is high and busy_o is
// low; exactly one result follows, shown for one cycle with done_o, and the
// receiver cannot stall it. Push, overflowing push, empty pop/peek, unknown
// kinds and search/update on an empty stack answer in the cycle after they are
// taken; pop and peek first read the RAM and pass through S_READ. Search and
// update walk the RAM from the bottom one entry per cycle and stop at the
// lowest matching entry, or after the top entry when nothing matches. busy_o
// is low in the cycle a result is shown, so the next request may be taken then.
// The capacity register may be written while idle.
module stack_with_search_update_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [2:0]                req_type_i,
  input  logic signed [31:0]        value_i,
  input  logic signed [31:0]        new_value_i,
  input  logic                      capacity_we_i,
  input  logic [lstk_pkg::CAP_W-1:0] capacity_i,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic signed [31:0]        data_o,
  output logic [lstk_pkg::IDX_W-1:0] index_o,
  output logic [lstk_pkg::CNT_W-1:0] count_o
);

  import lstk_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CAP_W-1:0]      capacity_q, capacity_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic [2:0]            req_q, req_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [DATA_WIDTH-1:0] repl_q, repl_d;
  status_e               status_q, status_d;
  logic [FIELD_W-1:0]    data_q, data_d;
  logic [IDX_W-1:0]      index_q, index_d;

  logic                  accept;
  logic [LIM_W-1:0]      limit;
  logic                  full;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  lstk_ram #(
    .DEPTH(DEPTH),
    .WIDTH(DATA_WIDTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign accept = start_i && (state_q == S_IDLE);
  // Saturate capacity at the RAM depth.
  assign limit  = (LIM_W'(capacity_q) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(capacity_q);
  assign full   = LIM_W'(count_q) >= limit;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    capacity_d = capacity_we_i ? capacity_i : capacity_q;
    done_d     = 1'b0;
    ptr_d      = ptr_q;
    req_d      = req_q;
    key_d      = key_q;
    repl_d     = repl_q;
    status_d   = status_q;
    data_d     = data_q;
    index_d    = index_q;
    ram_we     = 1'b0;
    ram_waddr  = ADDR_W'(count_q);
    ram_wdata  = key_d;
    ram_re     = 1'b0;
    ram_raddr  = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d    = req_type_i;
          key_d    = to_word(value_i);
          repl_d   = to_word(new_value_i);
          status_d = ST_OK;
          data_d   = '0;
          index_d  = '0;
          case (req_type_i)
            REQ_PUSH: begin
              done_d = 1'b1;
              if (full) begin
                status_d = ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(count_q);
                ram_wdata = key_d;
                index_d   = IDX_W'(count_q);
                count_d   = count_q + CNT_W'(1);
              end
            end
            REQ_POP, REQ_PEEK: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(count_q - CNT_W'(1));
                state_d   = S_READ;
                if (req_type_i == REQ_POP) begin
                  count_d = count_q - CNT_W'(1);
                end
              end
            end
            REQ_SEARCH, REQ_UPDATE: begin
              if (count_q == '0) begin
                status_d = ST_NOT_FOUND;
                done_d   = 1'b1;
              end else begin
                // Issue the bottom entry; compare it next cycle.
                ram_re    = 1'b1;
                ram_raddr = '0;
                ptr_d     = CNT_W'(1);
                state_d   = S_SCAN;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        data_d  = from_word(ram_rdata);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        // Data on the read port belongs to position ptr_q - 1.
        if (ram_rdata == key_q) begin
          index_d = IDX_W'(ptr_q - CNT_W'(1));
          if (req_q == REQ_UPDATE) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(ptr_q - CNT_W'(1));
            ram_wdata = repl_q;
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (ptr_q == count_q) begin
          status_d = ST_NOT_FOUND;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(ptr_q);
          ptr_d     = ptr_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      capacity_q <= CAP_W'(128);
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      capacity_q <= capacity_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    req_q    <= req_d;
    key_q    <= key_d;
    repl_q   <= repl_d;
    status_q <= status_d;
    data_q   <= data_d;
    index_q  <= index_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign data_o   = data_q;
  assign index_o  = index_q;
  assign count_o  = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_scan_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (ptr_q != '0) && (ptr_q <= count_q))
    else $error("scan pointer outside stored entries");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_PUSH) && !full)
      |=> (count_q == $past(count_q) + CNT_W'(1)) && done_q)
    else $error("accepted push did not add an entry");

  a_busy_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> !done_o)
    else $error("result shown while a multi-cycle request starts");

  a_count_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> $stable(count_q))
    else $error("entry count changed during a scan");

endmodule

>>> rtl/core/lstk_ram.sv
module lstk_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> verif/tb_stack_with_search_update_top.sv
`timescale 1ns / 1ps

class stack_scoreboard;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] data;
    logic [6:0]  index;
    logic [7:0]  count;
  } stack_result_t;

  stack_result_t result_q[$];
  logic [31:0]   entries[lstk_pkg::DEPTH];
  int unsigned   held;
  int unsigned   capacity;
  int unsigned   errors;

  function new();
    held     = 0;
    capacity = 128;
    errors   = 0;
  endfunction

  function void set_capacity(logic [7:0] c);
    capacity = 32'(c);
  endfunction

  function int unsigned pending();
    return result_q.size();
  endfunction

  function logic [31:0] entry_at(int unsigned i);
    return entries[i];
  endfunction

  function int find_lowest(logic [31:0] key);
    for (int unsigned i = 0; i < held; i++) begin
      if (entries[i] == key) return i;
    end
    return -1;
  endfunction

  // Predict the result of one accepted item and advance the stack state.
  function void note_request(logic [2:0] req, logic [31:0] val, logic [31:0] nv);
    stack_result_t r;
    int            pos;
    int unsigned   lim;
    r.status = lstk_pkg::ST_OK;
    r.data   = '0;
    r.index  = '0;
    lim      = (capacity > lstk_pkg::DEPTH) ? lstk_pkg::DEPTH : capacity;
    case (req)
      lstk_pkg::REQ_PUSH: begin
        if (held >= lim) begin
          r.status = lstk_pkg::ST_OVERFLOW;
        end else begin
          entries[held] = val;
          r.index       = 7'(held);
          held++;
        end
      end
      lstk_pkg::REQ_POP: begin
        if (held == 0) begin
          r.status = lstk_pkg::ST_EMPTY;
        end else begin
          held--;
          r.data = entries[held];
        end
      end
      lstk_pkg::REQ_PEEK: begin
        if (held == 0) r.status = lstk_pkg::ST_EMPTY;
        else r.data = entries[held-1];
      end
      lstk_pkg::REQ_SEARCH: begin
        pos = find_lowest(val);
        if (pos < 0) r.status = lstk_pkg::ST_NOT_FOUND;
        else r.index = 7'(pos);
      end
      lstk_pkg::REQ_UPDATE: begin
        pos = find_lowest(val);
        if (pos < 0) begin
          r.status = lstk_pkg::ST_NOT_FOUND;
        end else begin
          entries[pos] = nv;
          r.index      = 7'(pos);
        end
      end
      default: begin
      end
    endcase
    r.count = 8'(held);
    result_q.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
    end
  endfunction

  function void check_result(logic [1:0] status, logic [31:0] data, logic [6:0] index,
                             logic [7:0] count);
    stack_result_t r;
    if (result_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual status %h data %h", $time,
               status, data);
      return;
    end
    r = result_q.pop_front();
    compare_field("status", 32'(r.status), 32'(status));
    compare_field("data", r.data, data);
    compare_field("index", 32'(r.index), 32'(index));
    compare_field("count", 32'(r.count), 32'(count));
  endfunction

endclass

module tb_stack_with_search_update_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               start_i;
  logic                               busy_o;
  logic [2:0]                         req_type_i;
  logic signed [31:0]                 value_i;
  logic signed [31:0]                 new_value_i;
  logic                               capacity_we_i;
  logic [lstk_pkg::CAP_W-1:0]         capacity_i;
  logic                               done_o;
  logic [1:0]                         status_o;
  logic signed [31:0]                 data_o;
  logic [lstk_pkg::IDX_W-1:0]         index_o;
  logic [lstk_pkg::CNT_W-1:0]         count_o;

  stack_scoreboard sb;
  int unsigned     cycles;
  logic [31:0]     value_pool[8];

  stack_with_search_update_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .new_value_i  (new_value_i),
    .capacity_we_i(capacity_we_i),
    .capacity_i   (capacity_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .data_o       (data_o),
    .index_o      (index_o),
    .count_o      (count_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(status_o, data_o, index_o, count_o);
  end

  // Present one item and hold it until the block takes it.
  task automatic issue(input logic [2:0] req, input logic [31:0] val, input logic [31:0] nv);
    start_i     <= 1'b1;
    req_type_i  <= req;
    value_i     <= val;
    new_value_i <= nv;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(req, val, nv);
  endtask

  task automatic pause(input int unsigned n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drain outstanding results, then write the capacity register.
  task automatic write_capacity(input logic [7:0] c);
    start_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    @(posedge clk_i);
    capacity_we_i <= 1'b1;
    capacity_i    <= c;
    @(posedge clk_i);
    capacity_we_i <= 1'b0;
    capacity_i    <= 8'($urandom);
    sb.set_capacity(c);
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return value_pool[$urandom_range(0, 7)];
  endfunction

  task automatic random_item(input int unsigned push_pct);
    int unsigned roll;
    logic [2:0]  req;
    logic [31:0] val;
    roll = $urandom_range(0, 99);
    if (roll < 3) req = 3'($urandom_range(5, 7));
    else if (roll < push_pct) req = lstk_pkg::REQ_PUSH;
    else req = 3'($urandom_range(1, 4));
    val = pick_value();
    // Aim searches and updates at held entries most of the time.
    if ((req == lstk_pkg::REQ_SEARCH || req == lstk_pkg::REQ_UPDATE) && sb.held > 0 &&
        $urandom_range(0, 3) != 0)
      val = sb.entry_at($urandom_range(0, sb.held - 1));
    issue(req, val, pick_value());
  endtask

  initial begin
    logic [7:0]  phase_cap[10];
    int unsigned phase_push[10];
    int unsigned burst_left;

    sb            = new();
    cycles        = 0;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    req_type_i    = '0;
    value_i       = '0;
    new_value_i   = '0;
    capacity_we_i = 1'b0;
    capacity_i    = '0;
    value_pool    = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      $urandom, $urandom, $urandom, $urandom};
    phase_cap     = '{8'd255, 8'd3, 8'd128, 8'd0, 8'd1, 8'd2,
                      8'($urandom_range(1, 16)), 8'd64, 8'd127, 8'($urandom_range(0, 255))};
    phase_push    = '{90, 50, 85, 50, 50, 55, 60, 20, 80, 50};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty stack, unknown kinds, field extremes, duplicates.
    issue(lstk_pkg::REQ_POP, 32'h0, 32'h0);
    issue(lstk_pkg::REQ_PEEK, 32'hFFFF_FFFF, 32'h0);
    issue(lstk_pkg::REQ_SEARCH, 32'h0, 32'h0);
    issue(lstk_pkg::REQ_UPDATE, 32'h0, 32'h5);
    issue(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(3'd6, 32'h1234_5678, 32'h0);
    issue(3'd7, 32'h8000_0000, 32'h7FFF_FFFF);
    issue(lstk_pkg::REQ_PUSH, 32'h7FFF_FFFF, 32'h0);
    issue(lstk_pkg::REQ_PUSH, 32'h8000_0000, 32'h0);
    issue(lstk_pkg::REQ_PUSH, 32'h0000_0000, 32'h0);
    issue(lstk_pkg::REQ_PUSH, 32'hFFFF_FFFF, 32'h0);
    issue(lstk_pkg::REQ_PUSH, 32'h8000_0000, 32'h0);
    issue(lstk_pkg::REQ_PEEK, 32'h0, 32'h0);
    issue(lstk_pkg::REQ_SEARCH, 32'h8000_0000, 32'h0);
    issue(lstk_pkg::REQ_SEARCH, 32'h0001_2345, 32'h0);
    issue(lstk_pkg::REQ_UPDATE, 32'h8000_0000, 32'h0000_0001);
    issue(lstk_pkg::REQ_UPDATE, 32'h0001_2345, 32'h0000_0002);
    issue(lstk_pkg::REQ_SEARCH, 32'h0000_0001, 32'h0);
    issue(lstk_pkg::REQ_POP, 32'h0, 32'h0);
    issue(lstk_pkg::REQ_POP, 32'h0, 32'h0);

    // Capacity below the count keeps entries; pushes overflow until drained.
    write_capacity(8'd2);
    issue(lstk_pkg::REQ_PUSH, 32'hA5A5_A5A5, 32'h0);
    issue(lstk_pkg::REQ_POP, 32'h0, 32'h0);
    issue(lstk_pkg::REQ_PUSH, 32'h5A5A_5A5A, 32'h0);
    issue(lstk_pkg::REQ_POP, 32'h0, 32'h0);
    issue(lstk_pkg::REQ_PUSH, 32'h0F0F_0F0F, 32'h0);
    write_capacity(8'd0);
    issue(lstk_pkg::REQ_PUSH, 32'hF0F0_F0F0, 32'h0);

    burst_left = 0;
    for (int p = 0; p < 10; p++) begin
      write_capacity(phase_cap[p]);
      for (int n = 0; n < 100; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
        end
        random_item(phase_push[p]);
        burst_left--;
      end
    end

    start_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lstk_pkg.sv
rtl/core/lstk_ram.sv
rtl/core/stack_with_search_update_top.sv
verif/tb_stack_with_search_update_top.sv
